// ===== rtl/note_match_evaluator_defines.svh =====
// ----------------------------------------------------------------------------
// Note match evaluator assertion macros
// Shared assertion wrappers for the note match evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef NOTE_MATCH_EVALUATOR_DEFINES_SVH
`define NOTE_MATCH_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define NME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define NME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NME_ASSERT(lbl, prop, msg)
`define NME_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/nme_pkg.sv =====
// ----------------------------------------------------------------------------
// Note match evaluator package
// Shared constants and codes for the note match evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package nme_pkg;
  localparam int NME_MAX_NOTES = 256;
  localparam int ONSET_W = 32;
  localparam int PITCH_W = 20;
  localparam int TOL_W = 16;
  localparam int LIMIT_W = 18;
  localparam int RATIO_W = 17;
  localparam int COUNT_OUT_W = 9;

  typedef enum logic [1:0] {
    OP_LOAD_REF = 2'd0,
    OP_LOAD_EST = 2'd1,
    OP_EVALUATE = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [0:0] {
    REG_ONSET_TOL   = 1'b0,
    REG_PITCH_LIMIT = 1'b1
  } reg_index_t;
endpackage
`default_nettype wire

// ===== rtl/nme_ram.sv =====
// ----------------------------------------------------------------------------
// Note match evaluator RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/note_match_evaluator.sv =====
// ----------------------------------------------------------------------------
// Note match evaluator
// Onset/pitch note matching with maximum bipartite matching and F1 scoring.
// ----------------------------------------------------------------------------
// Load reference notes (tuser 0) and estimated notes (tuser 1) one item per
// cycle; a load into a full list is dropped and flags overflow. An evaluate
// item (tuser 2) starts a run: a clearing pass over all MAX_NOTES entries of
// the partner and visited memories, then one augmenting-path search per
// reference note, walking the estimated list through the shared hit unit in
// steps per candidate (memory read, onset/pitch compare, ratio multiply,
// decision), with stack pushes, pops and augmenting writes as needed. The run
// ends with up to three 17-step restoring divisions for precision, recall and
// F1 on one shared subtractor; a zero denominator gives a zero ratio without
// a division. The block takes no item while a run is in progress; loads are
// taken while a result still waits on the output. tuser 3 is ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "note_match_evaluator_defines.svh"
module note_match_evaluator
  import nme_pkg::*;
#(
  parameter int MAX_NOTES = NME_MAX_NOTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [31:0] onset_time, [51:32] pitch_freq, [55:52] zero
  input  wire logic [55:0] s_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [8:0] true_pos, [17:9] false_pos, [26:18] false_neg, [43:27] precision_q,
  // [60:44] recall_q, [77:61] f1_q, [78] overflowed, [79] zero
  output logic      [79:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [17:0] cfg_data
);
  localparam int IDXW  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CNTW  = IDXW + 1;
  localparam int NOTEW = ONSET_W + PITCH_W;
  localparam int DENW  = CNTW + 1;
  localparam int DVW   = CNTW + 20;
  localparam int PRODW = PITCH_W + LIMIT_W;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_NOTES - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(MAX_NOTES);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CLR    = 13'b0000000000010,
    S_NEXTU  = 13'b0000000000100,
    S_CHK    = 13'b0000000001000,
    S_HA     = 13'b0000000010000,
    S_HB     = 13'b0000000100000,
    S_HC     = 13'b0000001000000,
    S_POP    = 13'b0000010000000,
    S_AUGW   = 13'b0000100000000,
    S_AUGWR  = 13'b0001000000000,
    S_DIVSET = 13'b0010000000000,
    S_DIVRUN = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  typedef enum logic [1:0] {
    DIV_PREC = 2'd0,
    DIV_REC  = 2'd1,
    DIV_F1   = 2'd2,
    DIV_NONE = 2'd3
  } div_sel_t;

  state_t state;
  div_sel_t div_sel;

  logic [TOL_W-1:0]   onset_tol;
  logic [LIMIT_W-1:0] pitch_limit;
  logic [CNTW-1:0]    ref_count, est_count, u, tp, cur_v;
  logic [IDXW-1:0]    cur_ref, top, clr_idx;
  logic               overflow;

  // Hit unit pipeline registers
  logic               gap_ok, lo_zero, vis_hit;
  logic [PITCH_W-1:0] hi, lo;
  logic [PRODW-1:0]   prod;
  logic [IDXW:0]      partner_r;

  // Divider
  logic [DVW-1:0]     rem, dsh;
  logic [RATIO_W-1:0] quo, quo_next, prec_r, rec_r, f1_r;
  logic [4:0]         div_cnt;
  logic [DENW-1:0]    div_num, div_den;
  logic               take;

  // Memory ports
  logic [NOTEW-1:0]  ref_rdata, est_rdata;
  logic [IDXW:0]     part_rdata, vis_rdata, part_wdata, vis_wdata;
  logic [2*IDXW-1:0] stk_rdata;
  logic              ref_we, est_we, part_we, vis_we, stk_we;
  logic [IDXW-1:0]   part_waddr, stk_raddr;
  logic              accept, hit;
  opcode_t           op;

  assign op       = opcode_t'(s_tuser);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign ref_we   = accept && (op == OP_LOAD_REF) && (ref_count != FULL_CNT);
  assign est_we   = accept && (op == OP_LOAD_EST) && (est_count != FULL_CNT);
  assign stk_raddr = top - IDXW'(1);
  assign stk_we   = (state == S_HC) && hit && !partner_r[IDXW];
  assign hit      = !lo_zero && gap_ok && !vis_hit
                    && ({2'b00, hi, 16'h0000} <= prod);
  assign take     = m_tvalid && m_tready;

  // Partner and visited write control: clear pass, hit marking, augment writes
  always_comb begin
    part_we    = 1'b0;
    part_waddr = cur_v[IDXW-1:0];
    part_wdata = {1'b0, cur_ref};
    vis_we     = 1'b0;
    vis_wdata  = {1'b1, u[IDXW-1:0]};
    case (state)
      S_CLR: begin
        part_we    = 1'b1;
        part_waddr = clr_idx;
        part_wdata = {1'b1, {IDXW{1'b0}}};
        vis_we     = 1'b1;
        vis_wdata  = '0;
      end
      S_HC: begin
        vis_we  = hit;
        part_we = hit && partner_r[IDXW];
      end
      S_AUGWR: begin
        part_we    = 1'b1;
        part_waddr = stk_rdata[IDXW-1:0];
        part_wdata = {1'b0, stk_rdata[2*IDXW-1:IDXW]};
      end
      default: begin
      end
    endcase
  end

  // Divider operands
  always_comb begin
    case (div_sel)
      DIV_PREC: begin
        div_num = DENW'(tp);
        div_den = DENW'(est_count);
      end
      DIV_REC: begin
        div_num = DENW'(tp);
        div_den = DENW'(ref_count);
      end
      DIV_F1: begin
        div_num = {tp, 1'b0};
        div_den = DENW'(ref_count) + DENW'(est_count);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  assign quo_next = {quo[RATIO_W-2:0], (rem >= dsh)};

  nme_ram #(.WIDTH(NOTEW), .DEPTH(MAX_NOTES)) u_ref_ram (
    .clk(clk), .we(ref_we), .waddr(ref_count[IDXW-1:0]),
    .wdata({s_tdata[51:32], s_tdata[31:0]}), .raddr(cur_ref), .rdata(ref_rdata)
  );
  nme_ram #(.WIDTH(NOTEW), .DEPTH(MAX_NOTES)) u_est_ram (
    .clk(clk), .we(est_we), .waddr(est_count[IDXW-1:0]),
    .wdata({s_tdata[51:32], s_tdata[31:0]}), .raddr(cur_v[IDXW-1:0]),
    .rdata(est_rdata)
  );
  nme_ram #(.WIDTH(IDXW+1), .DEPTH(MAX_NOTES)) u_part_ram (
    .clk(clk), .we(part_we), .waddr(part_waddr), .wdata(part_wdata),
    .raddr(cur_v[IDXW-1:0]), .rdata(part_rdata)
  );
  nme_ram #(.WIDTH(IDXW+1), .DEPTH(MAX_NOTES)) u_vis_ram (
    .clk(clk), .we(vis_we), .waddr(part_waddr), .wdata(vis_wdata),
    .raddr(cur_v[IDXW-1:0]), .rdata(vis_rdata)
  );
  nme_ram #(.WIDTH(2*IDXW), .DEPTH(MAX_NOTES)) u_stk_ram (
    .clk(clk), .we(stk_we), .waddr(top), .wdata({cur_ref, cur_v[IDXW-1:0]}),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      onset_tol   <= TOL_W'(500);
      pitch_limit <= LIMIT_W'(67456);
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_ONSET_TOL:   onset_tol   <= cfg_data[TOL_W-1:0];
        REG_PITCH_LIMIT: pitch_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hit unit datapath: compare, multiply, decide
  always_ff @(posedge clk) begin
    if (state == S_HA) begin
      gap_ok    <= ((ref_rdata[ONSET_W-1:0] > est_rdata[ONSET_W-1:0])
                    ? (ref_rdata[ONSET_W-1:0] - est_rdata[ONSET_W-1:0])
                    : (est_rdata[ONSET_W-1:0] - ref_rdata[ONSET_W-1:0]))
                   <= ONSET_W'(onset_tol);
      if (ref_rdata[NOTEW-1:ONSET_W] > est_rdata[NOTEW-1:ONSET_W]) begin
        hi <= ref_rdata[NOTEW-1:ONSET_W];
        lo <= est_rdata[NOTEW-1:ONSET_W];
      end else begin
        hi <= est_rdata[NOTEW-1:ONSET_W];
        lo <= ref_rdata[NOTEW-1:ONSET_W];
      end
      lo_zero   <= (ref_rdata[NOTEW-1:ONSET_W] == '0)
                   || (est_rdata[NOTEW-1:ONSET_W] == '0);
      vis_hit   <= (vis_rdata == {1'b1, u[IDXW-1:0]});
      partner_r <= part_rdata;
    end
    if (state == S_HB) begin
      prod <= PRODW'(lo) * PRODW'(pitch_limit);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ref_count <= '0;
      est_count <= '0;
      overflow  <= 1'b0;
      m_tvalid  <= 1'b0;
      div_sel   <= DIV_PREC;
    end else begin
      if (take) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_LOAD_REF: begin
                if (ref_count == FULL_CNT) overflow <= 1'b1;
                else ref_count <= ref_count + CNTW'(1);
              end
              OP_LOAD_EST: begin
                if (est_count == FULL_CNT) overflow <= 1'b1;
                else est_count <= est_count + CNTW'(1);
              end
              OP_EVALUATE: begin
                clr_idx <= '0;
                state   <= S_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          clr_idx <= clr_idx + IDXW'(1);
          if (clr_idx == LAST_IDX) begin
            u     <= '0;
            tp    <= '0;
            state <= S_NEXTU;
          end
        end
        S_NEXTU: begin
          if (u == ref_count) begin
            div_sel <= DIV_PREC;
            state   <= S_DIVSET;
          end else begin
            cur_ref <= u[IDXW-1:0];
            cur_v   <= '0;
            top     <= '0;
            state   <= S_CHK;
          end
        end
        S_CHK: begin
          // Memory reads for the new candidate settle during this cycle
          if (cur_v >= est_count) begin
            if (top == '0) begin
              u     <= u + CNTW'(1);
              state <= S_NEXTU;
            end else begin
              state <= S_POP;
            end
          end else begin
            state <= S_HA;
          end
        end
        S_HA: state <= S_HB;
        S_HB: state <= S_HC;
        S_HC: begin
          if (!hit) begin
            cur_v <= cur_v + CNTW'(1);
            state <= S_CHK;
          end else if (partner_r[IDXW]) begin
            // Free estimate: flip the path back to the root
            if (top == '0) begin
              tp    <= tp + CNTW'(1);
              u     <= u + CNTW'(1);
              state <= S_NEXTU;
            end else begin
              state <= S_AUGW;
            end
          end else begin
            // Descend into the reference that holds this estimate
            top     <= top + IDXW'(1);
            cur_ref <= partner_r[IDXW-1:0];
            cur_v   <= '0;
            state   <= S_CHK;
          end
        end
        S_POP: begin
          cur_ref <= stk_rdata[2*IDXW-1:IDXW];
          cur_v   <= CNTW'(stk_rdata[IDXW-1:0]) + CNTW'(1);
          top     <= top - IDXW'(1);
          state   <= S_CHK;
        end
        S_AUGW: state <= S_AUGWR;
        S_AUGWR: begin
          top <= top - IDXW'(1);
          if (top == IDXW'(1)) begin
            tp    <= tp + CNTW'(1);
            u     <= u + CNTW'(1);
            state <= S_NEXTU;
          end else begin
            state <= S_AUGW;
          end
        end
        S_DIVSET: begin
          if (div_den == '0) begin
            case (div_sel)
              DIV_PREC: prec_r <= '0;
              DIV_REC:  rec_r  <= '0;
              default:  f1_r   <= '0;
            endcase
            if (div_sel == DIV_F1) state <= S_DONE;
            else div_sel <= div_sel_t'(div_sel + 2'd1);
          end else begin
            // Round to nearest: (num * 2^17 + den) / (2 * den)
            rem     <= (DVW'(div_num) << 17) + DVW'(div_den);
            dsh     <= DVW'(div_den) << 17;
            quo     <= '0;
            div_cnt <= '0;
            state   <= S_DIVRUN;
          end
        end
        S_DIVRUN: begin
          if (rem >= dsh) rem <= rem - dsh;
          dsh     <= dsh >> 1;
          quo     <= quo_next;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd16) begin
            case (div_sel)
              DIV_PREC: prec_r <= quo_next;
              DIV_REC:  rec_r  <= quo_next;
              default:  f1_r   <= quo_next;
            endcase
            if (div_sel == DIV_F1) begin
              state <= S_DONE;
            end else begin
              div_sel <= div_sel_t'(div_sel + 2'd1);
              state   <= S_DIVSET;
            end
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            ref_count <= '0;
            est_count <= '0;
            overflow  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, overflow, f1_r, rec_r, prec_r,
                  COUNT_OUT_W'(ref_count - tp),
                  COUNT_OUT_W'(est_count - tp),
                  COUNT_OUT_W'(tp)};
    end
  end

  `NME_ASSERT(a_ref_count_cap, ref_count <= FULL_CNT, "reference count beyond capacity")
  `NME_ASSERT(a_tp_bound, (state != S_IDLE && state != S_CLR) |-> (tp <= ref_count && tp <= est_count), "true positives exceed a list count")
  `NME_ASSERT(a_full_flags, (accept && op == OP_LOAD_REF && ref_count == FULL_CNT) |=> overflow, "dropped load did not flag overflow")
  `NME_ASSERT(a_done_emits, ($past(state == S_DONE) && state == S_IDLE) |-> m_tvalid, "finished run produced no item")
  `NME_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !m_tvalid), "reset did not idle the block")
endmodule
`default_nettype wire

// ===== tb/note_match_evaluator_tb.sv =====
// ----------------------------------------------------------------------------
// Note match evaluator testbench
// Loads reference and estimated notes, runs evaluates and checks each score
// item against a built-in matcher that keeps its own copy of the note lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module note_match_evaluator_tb;
  import nme_pkg::*;

  localparam int NOTES = NME_MAX_NOTES;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int ITEM_GOAL = 1750;

  typedef struct packed {
    logic [8:0]  true_pos;
    logic [8:0]  false_pos;
    logic [8:0]  false_neg;
    logic [16:0] precision_q;
    logic [16:0] recall_q;
    logic [16:0] f1_q;
    logic        overflowed;
  } score_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [31:0] onset_time, [51:32] pitch_freq, [55:52] zero
  logic [55:0] s_tdata = '0;
  // [1:0] opcode
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [8:0] true_pos, [17:9] false_pos, [26:18] false_neg, [43:27] precision_q,
  // [60:44] recall_q, [77:61] f1_q, [78] overflowed, [79] zero
  logic [79:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_addr = '0;
  logic [17:0] cfg_data = '0;

  note_match_evaluator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow state of the block
  logic [15:0] onset_tol;
  logic [17:0] ratio_limit;
  logic [31:0] ref_on [NOTES];
  logic [19:0] ref_pitch [NOTES];
  logic [31:0] est_on [NOTES];
  logic [19:0] est_pitch [NOTES];
  int          ref_cnt, est_cnt;
  bit          list_overflow;
  int          est_partner [NOTES];
  bit          est_seen [NOTES];

  score_t score_q[$];
  int     errors = 0;
  int     items_sent = 0;
  int     cycles = 0;
  bit     steady = 1'b0;   // when set, neither side idles

  // ---------------------------------------------------------------------------
  // Matcher
  // ---------------------------------------------------------------------------
  function automatic bit note_hit(int r, int e);
    logic [32:0] gap;
    logic [63:0] hi, lo;
    gap = (ref_on[r] > est_on[e]) ? ref_on[r] - est_on[e] : est_on[e] - ref_on[r];
    hi = (ref_pitch[r] > est_pitch[e]) ? ref_pitch[r] : est_pitch[e];
    lo = (ref_pitch[r] > est_pitch[e]) ? est_pitch[e] : ref_pitch[r];
    if (gap > onset_tol || lo == 0) return 1'b0;
    return (hi << 16) <= lo * ratio_limit;
  endfunction

  // Kuhn augmenting path; any maximum matching has the same size
  function automatic bit find_path(int r);
    for (int e = 0; e < est_cnt; e++) begin
      if (!est_seen[e] && note_hit(r, e)) begin
        est_seen[e] = 1'b1;
        if (est_partner[e] < 0 || find_path(est_partner[e])) begin
          est_partner[e] = r;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [16:0] q16_ratio(longint unsigned num, longint unsigned den);
    if (den == 0) return '0;
    return 17'((num * 131072 + den) / (2 * den));
  endfunction

  function automatic void score_item(opcode_t op, logic [31:0] onset, logic [19:0] pitch);
    score_t s;
    int tp;
    if (op == OP_LOAD_REF) begin
      if (ref_cnt >= NOTES) list_overflow = 1'b1;
      else begin
        ref_on[ref_cnt] = onset; ref_pitch[ref_cnt] = pitch; ref_cnt++;
      end
    end else if (op == OP_LOAD_EST) begin
      if (est_cnt >= NOTES) list_overflow = 1'b1;
      else begin
        est_on[est_cnt] = onset; est_pitch[est_cnt] = pitch; est_cnt++;
      end
    end else if (op == OP_EVALUATE) begin
      tp = 0;
      for (int e = 0; e < NOTES; e++) est_partner[e] = -1;
      for (int r = 0; r < ref_cnt; r++) begin
        for (int e = 0; e < NOTES; e++) est_seen[e] = 1'b0;
        if (find_path(r)) tp++;
      end
      s.true_pos    = 9'(tp);
      s.false_pos   = 9'(est_cnt - tp);
      s.false_neg   = 9'(ref_cnt - tp);
      s.precision_q = q16_ratio(tp, est_cnt);
      s.recall_q    = q16_ratio(tp, ref_cnt);
      s.f1_q        = (tp == 0) ? '0 : q16_ratio(2 * tp, ref_cnt + est_cnt);
      s.overflowed  = list_overflow;
      score_q.push_back(s);
      ref_cnt = 0; est_cnt = 0; list_overflow = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_note(opcode_t op, logic [31:0] onset, logic [19:0] pitch);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, pitch, onset};
    do @(posedge clk); while (!s_tready);
    score_item(op, onset, pitch);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic evaluate();
    send_note(OP_EVALUATE, $urandom, 20'($urandom));
  endtask

  // Hold the stream until the last score has drained, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (score_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [17:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ONSET_TOL) onset_tol = value[15:0];
    else ratio_limit = value;
  endtask

  // One frame: refs in tight clusters, estimates mostly near some ref
  task automatic run_frame(int nref, int nest, int hit_pct);
    logic [31:0] base, on;
    logic [63:0] p;
    int          j;
    base = $urandom;
    for (int i = 0; i < nref; i++) begin
      if ($urandom_range(0, 19) == 0) send_note(OP_NONE, $urandom, 20'($urandom));
      send_note(OP_LOAD_REF, base + $urandom_range(0, 3 * onset_tol + 10),
                20'($urandom_range(1, 20'hFFFFF)));
    end
    for (int i = 0; i < nest; i++) begin
      if (ref_cnt > 0 && $urandom_range(0, 99) < hit_pct) begin
        j  = $urandom_range(0, ref_cnt - 1);
        on = ref_on[j] + $urandom_range(0, 2 * onset_tol + 4) - onset_tol - 2;
        p  = (64'(ref_pitch[j]) * $urandom_range(60000, 71000)) >> 16;
        if (p == 0) p = 1;
        if (p > 64'hFFFFF) p = 64'hFFFFF;
        send_note(OP_LOAD_EST, on, 20'(p));
      end else begin
        send_note(OP_LOAD_EST, base + $urandom_range(0, 3 * onset_tol + 10),
                  20'($urandom_range(0, 20'hFFFFF)));
      end
    end
    evaluate();
  endtask

  // ---------------------------------------------------------------------------
  // Score checker
  // ---------------------------------------------------------------------------
  initial begin
    int     stall;
    score_t got, want;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = {m_tdata[8:0], m_tdata[17:9], m_tdata[26:18], m_tdata[43:27],
             m_tdata[60:44], m_tdata[77:61], m_tdata[78]};
      if (score_q.size() == 0) begin
        $error("score item with none expected: %h", m_tdata);
        errors++;
      end else begin
        want = score_q.pop_front();
        if (got.true_pos != want.true_pos) begin
          $error("true_pos exp %0d got %0d", want.true_pos, got.true_pos); errors++;
        end
        if (got.false_pos != want.false_pos) begin
          $error("false_pos exp %0d got %0d", want.false_pos, got.false_pos); errors++;
        end
        if (got.false_neg != want.false_neg) begin
          $error("false_neg exp %0d got %0d", want.false_neg, got.false_neg); errors++;
        end
        if (got.precision_q != want.precision_q) begin
          $error("precision_q exp %0d got %0d", want.precision_q, got.precision_q);
          errors++;
        end
        if (got.recall_q != want.recall_q) begin
          $error("recall_q exp %0d got %0d", want.recall_q, got.recall_q); errors++;
        end
        if (got.f1_q != want.f1_q) begin
          $error("f1_q exp %0d got %0d", want.f1_q, got.f1_q); errors++;
        end
        if (got.overflowed != want.overflowed) begin
          $error("overflowed exp %0d got %0d", want.overflowed, got.overflowed); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("note_match_evaluator_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // empty lists, and refs only
    evaluate();
    send_note(OP_LOAD_REF, 32'd100, 20'd256);
    evaluate();
    // onset extremes: huge gap misses, exact tolerance hits
    send_note(OP_LOAD_REF, 32'h0, 20'h1);
    send_note(OP_LOAD_EST, 32'hFFFFFFFF, 20'h1);
    send_note(OP_LOAD_REF, 32'hFFFFFFFF, 20'hFFFFF);
    send_note(OP_LOAD_EST, 32'hFFFFFFFF - 500, 20'hFFFFF);
    evaluate();
    // pitch ratio exactly at the limit and one past it
    send_note(OP_LOAD_REF, 32'd1000, 20'd65536);
    send_note(OP_LOAD_EST, 32'd1000, 20'd67456);
    send_note(OP_LOAD_REF, 32'd5000, 20'd65536);
    send_note(OP_LOAD_EST, 32'd5000, 20'd67457);
    evaluate();
    // zero pitch never hits; unused opcode is ignored
    send_note(OP_LOAD_REF, 32'd7, 20'd0);
    send_note(OP_NONE, 32'd7, 20'd0);
    send_note(OP_LOAD_EST, 32'd7, 20'd0);
    send_note(OP_LOAD_EST, 32'd7, 20'd300);
    evaluate();
    // contention: greedy choice must be undone by an augmenting path
    send_note(OP_LOAD_REF, 32'd0, 20'd1000);
    send_note(OP_LOAD_REF, 32'd600, 20'd1000);
    send_note(OP_LOAD_EST, 32'd300, 20'd1000);
    send_note(OP_LOAD_EST, 32'd0, 20'd1000);
    evaluate();
  endtask

  task automatic test_config_extremes();
    drain();
    write_reg(REG_ONSET_TOL, 18'd0);
    write_reg(REG_PITCH_LIMIT, 18'd65536);
    repeat (6) run_frame($urandom_range(0, 8), $urandom_range(0, 8), 80);
    send_note(OP_LOAD_REF, 32'd9, 20'd777);
    send_note(OP_LOAD_EST, 32'd9, 20'd777);
    evaluate();
    drain();
    write_reg(REG_ONSET_TOL, 18'd65535);
    write_reg(REG_PITCH_LIMIT, 18'd131072);
    repeat (6) run_frame($urandom_range(0, 10), $urandom_range(0, 10), 70);
    drain();
    write_reg(REG_ONSET_TOL, 18'd500);
    write_reg(REG_PITCH_LIMIT, 18'd67456);
  endtask

  task automatic test_full_lists();
    // every ref matches its own estimate: a complete matching of full lists
    for (int i = 0; i < NOTES; i++) send_note(OP_LOAD_REF, i * 100000, 20'(1000 + i));
    for (int i = 0; i < NOTES; i++) send_note(OP_LOAD_EST, i * 100000 + 3, 20'(1000 + i));
    evaluate();
  endtask

  task automatic test_overflow();
    steady = 1'b1;
    for (int i = 0; i <= NOTES; i++) send_note(OP_LOAD_REF, $urandom, 20'($urandom));
    evaluate();
    for (int i = 0; i <= NOTES; i++) send_note(OP_LOAD_EST, $urandom, 20'($urandom));
    send_note(OP_LOAD_REF, $urandom, 20'($urandom));
    evaluate();
    steady = 1'b0;
  endtask

  task automatic test_random();
    int phase = 0;
    while (items_sent < ITEM_GOAL) begin
      run_frame($urandom_range(0, 12), $urandom_range(0, 12), 75);
      if (++phase % 25 == 0) begin
        drain();
        write_reg(REG_ONSET_TOL, 18'($urandom_range(0, 2000)));
        write_reg(REG_PITCH_LIMIT, 18'($urandom_range(65536, 131072)));
        steady = ($urandom_range(0, 2) == 0);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    onset_tol = 16'd500; ratio_limit = 18'd67456;
    ref_cnt = 0; est_cnt = 0; list_overflow = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_config_extremes();
    test_full_lists();
    test_overflow();
    test_random();
    drain();
    if (errors == 0) begin
      $display("note_match_evaluator_tb OK");
    end else begin
      $display("note_match_evaluator_tb NOT OK");
    end
    $finish;
  end
endmodule
